[hdl/cle4w_pkg.sv]
package cle4w_pkg;

	// Request codes carried in the op field
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_CMD  = 2'd1;
	localparam logic [1:0] OP_DATA = 2'd2;
	localparam logic [1:0] OP_INIT = 2'd3;

	// Configuration register indexes
	localparam logic CFG_UNIT = 1'b0;
	localparam logic CFG_LONG = 1'b1;

	// Register reset values
	localparam logic [15:0] UNIT_RESET = 16'd1200;
	localparam logic [19:0] LONG_RESET = 20'd24000;

	// Power-up step counter codes
	localparam logic [3:0] ISTEP_OFF  = 4'd0;
	localparam logic [3:0] ISTEP_N1   = 4'd1;
	localparam logic [3:0] ISTEP_N2   = 4'd2;
	localparam logic [3:0] ISTEP_N3   = 4'd3;
	localparam logic [3:0] ISTEP_N4   = 4'd4;
	localparam logic [3:0] ISTEP_CMD0 = 4'd5;
	localparam logic [3:0] ISTEP_END  = 4'd9;

	// Power-up nibbles, placed in the high half of the byte register
	localparam logic [7:0] NIB3_BYTE = 8'h30;
	localparam logic [7:0] NIB2_BYTE = 8'h20;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_PE1,
		PH_PL1,
		PH_PE2,
		PH_PRE,
		PH_NH_HI,
		PH_NH_LO,
		PH_NL_HI,
		PH_NL_LO,
		PH_IN_HI,
		PH_IN_LO,
		PH_IWAIT
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [19:0] wait_count;
		logic [7:0]  byte_hold;
		logic        select_hold;
		logic [3:0]  init_step;
		logic        busy_seen;
		logic        pin_e;
		logic        pin_rs;
		logic        pin_rw;
		logic [3:0]  pin_nib;
		logic        pin_drive;
	} state_t;

	typedef struct packed {
		logic       lcd_e;
		logic       lcd_rs;
		logic       lcd_rw;
		logic [3:0] lcd_nibble;
		logic       bus_drive;
		logic       ready_res;
		logic       rejected;
	} res_t;

	localparam state_t ST_RESET = '{
		phase:       PH_IDLE,
		wait_count:  20'd0,
		byte_hold:   8'd0,
		select_hold: 1'b0,
		init_step:   ISTEP_OFF,
		busy_seen:   1'b0,
		pin_e:       1'b0,
		pin_rs:      1'b0,
		pin_rw:      1'b0,
		pin_nib:     4'd0,
		pin_drive:   1'b0
	};

	// Command bytes of the power-up sequence
	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'h01;
			3'd1: b = 8'h28;
			3'd2: b = 8'h0F;
			3'd3: b = 8'h06;
			default: b = 8'h01;
		endcase
		return b;
	endfunction

endpackage

[hdl/cle4w_req_if.sv]
interface cle4w_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] value;
	logic       busy_line;

	modport source (output valid, output op, output value, output busy_line, input ready);
	modport sink (input valid, input op, input value, input busy_line, output ready);
endinterface

[hdl/cle4w_res_if.sv]
interface cle4w_res_if;
	logic       valid;
	logic       ready;
	logic       lcd_e;
	logic       lcd_rs;
	logic       lcd_rw;
	logic [3:0] lcd_nibble;
	logic       bus_drive;
	logic       ready_res;
	logic       rejected;

	modport source (
		output valid, output lcd_e, output lcd_rs, output lcd_rw, output lcd_nibble,
		output bus_drive, output ready_res, output rejected, input ready
	);
	modport sink (
		input valid, input lcd_e, input lcd_rs, input lcd_rw, input lcd_nibble,
		input bus_drive, input ready_res, input rejected, output ready
	);
endinterface

[hdl/cle4w_step.sv]
module cle4w_step import cle4w_pkg::*; (
	input  state_t      cur,
	input  logic [1:0]  op,
	input  logic [7:0]  value,
	input  logic        busy_line,
	input  logic [15:0] unit_ticks,
	input  logic [19:0] long_ticks,
	output state_t      nxt,
	output res_t        result
);

	logic [15:0] ulen;
	logic [19:0] unit_w;
	logic [19:0] dbl_w;
	logic [19:0] long_w;
	logic [3:0]  step_inc;
	logic        rej;

	// A zero wait register counts as one tick
	assign ulen   = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
	assign unit_w = {4'd0, ulen};
	assign dbl_w  = {3'd0, ulen, 1'b0};
	assign long_w = (long_ticks == 20'd0) ? 20'd1 : long_ticks;
	assign step_inc = cur.init_step + 4'd1;

	always_comb begin
		nxt = cur;
		rej = 1'b0;

		// Take a request only while idle
		if (op != OP_TICK) begin
			if (cur.phase != PH_IDLE) begin
				rej = 1'b1;
			end else if (op == OP_INIT) begin
				nxt.init_step   = ISTEP_N1;
				nxt.select_hold = 1'b0;
				nxt.byte_hold   = NIB3_BYTE;
				nxt.phase       = PH_IN_HI;
				nxt.wait_count  = unit_w;
			end else begin
				nxt.init_step   = ISTEP_OFF;
				nxt.select_hold = (op == OP_DATA);
				nxt.byte_hold   = value;
				nxt.busy_seen   = 1'b0;
				nxt.phase       = PH_PE1;
				nxt.wait_count  = unit_w;
			end
		end

		if (nxt.phase != PH_IDLE) begin
			// Drive pins for the current segment
			unique case (nxt.phase)
				PH_PE1, PH_PE2: begin
					nxt.pin_e = 1'b1; nxt.pin_rs = 1'b0; nxt.pin_rw = 1'b1; nxt.pin_drive = 1'b0;
				end
				PH_PL1: begin
					nxt.pin_e = 1'b0; nxt.pin_rs = 1'b0; nxt.pin_rw = 1'b1; nxt.pin_drive = 1'b0;
				end
				PH_PRE: begin
					nxt.pin_e = 1'b0; nxt.pin_rs = 1'b0; nxt.pin_rw = 1'b1; nxt.pin_drive = 1'b1;
				end
				PH_NH_HI: begin
					nxt.pin_nib = nxt.byte_hold[7:4];
					nxt.pin_e = 1'b1; nxt.pin_rs = nxt.select_hold; nxt.pin_rw = 1'b0;
					nxt.pin_drive = 1'b1;
				end
				PH_NL_HI: begin
					nxt.pin_nib = nxt.byte_hold[3:0];
					nxt.pin_e = 1'b1; nxt.pin_rs = nxt.select_hold; nxt.pin_rw = 1'b0;
					nxt.pin_drive = 1'b1;
				end
				PH_NH_LO, PH_NL_LO: begin
					nxt.pin_e = 1'b0; nxt.pin_rs = nxt.select_hold; nxt.pin_rw = 1'b0;
					nxt.pin_drive = 1'b1;
				end
				PH_IN_HI: begin
					nxt.pin_nib = nxt.byte_hold[7:4];
					nxt.pin_e = 1'b1; nxt.pin_rs = 1'b0; nxt.pin_rw = 1'b0; nxt.pin_drive = 1'b1;
				end
				PH_IN_LO, PH_IWAIT: begin
					nxt.pin_e = 1'b0; nxt.pin_rs = 1'b0; nxt.pin_rw = 1'b0; nxt.pin_drive = 1'b1;
				end
				default: nxt.pin_e = 1'b0;
			endcase

			// Sample D7 on the last tick of the first E high level
			if (nxt.phase == PH_PE1 && nxt.wait_count <= 20'd1) nxt.busy_seen = busy_line;
			if (nxt.wait_count != 20'd0) nxt.wait_count = nxt.wait_count - 20'd1;

			if (nxt.wait_count == 20'd0) begin
				unique case (nxt.phase)
					PH_PE1: begin nxt.phase = PH_PL1; nxt.wait_count = unit_w; end
					PH_PL1: begin nxt.phase = PH_PE2; nxt.wait_count = unit_w; end
					PH_PE2: begin
						if (nxt.busy_seen) begin
							nxt.phase = PH_PE1; nxt.wait_count = unit_w;
						end else begin
							nxt.phase = PH_PRE;
							nxt.wait_count = nxt.select_hold ? unit_w : dbl_w;
						end
					end
					PH_PRE:   begin nxt.phase = PH_NH_HI; nxt.wait_count = unit_w; end
					PH_NH_HI: begin nxt.phase = PH_NH_LO; nxt.wait_count = 20'd1; end
					PH_NH_LO: begin nxt.phase = PH_NL_HI; nxt.wait_count = unit_w; end
					PH_NL_HI: begin nxt.phase = PH_NL_LO; nxt.wait_count = 20'd1; end
					PH_NL_LO: begin
						// Chain the next power-up command, else finish
						if (nxt.init_step >= ISTEP_CMD0 && nxt.init_step < ISTEP_END) begin
							nxt.init_step   = step_inc;
							nxt.select_hold = 1'b0;
							nxt.byte_hold   = init_cmd(3'(step_inc - ISTEP_CMD0));
							nxt.busy_seen   = 1'b0;
							nxt.phase       = PH_PE1;
							nxt.wait_count  = unit_w;
						end else begin
							nxt.init_step = ISTEP_OFF; nxt.phase = PH_IDLE; nxt.wait_count = 20'd0;
						end
					end
					PH_IN_HI: begin nxt.phase = PH_IN_LO; nxt.wait_count = 20'd1; end
					PH_IN_LO: begin
						priority if (nxt.init_step == ISTEP_N1) begin
							nxt.phase = PH_IWAIT; nxt.wait_count = long_w;
						end else if (nxt.init_step == ISTEP_N2) begin
							nxt.phase = PH_IWAIT; nxt.wait_count = unit_w;
						end else if (nxt.init_step == ISTEP_N3) begin
							nxt.init_step  = ISTEP_N4;
							nxt.byte_hold  = NIB2_BYTE;
							nxt.phase      = PH_IN_HI;
							nxt.wait_count = unit_w;
						end else if (nxt.init_step == ISTEP_N4) begin
							nxt.init_step   = ISTEP_CMD0;
							nxt.select_hold = 1'b0;
							nxt.byte_hold   = init_cmd(3'd0);
							nxt.busy_seen   = 1'b0;
							nxt.phase       = PH_PE1;
							nxt.wait_count  = unit_w;
						end else begin
							nxt.init_step = ISTEP_OFF; nxt.phase = PH_IDLE; nxt.wait_count = 20'd0;
						end
					end
					PH_IWAIT: begin
						nxt.init_step  = step_inc;
						nxt.byte_hold  = NIB3_BYTE;
						nxt.phase      = PH_IN_HI;
						nxt.wait_count = unit_w;
					end
					default: begin
						nxt.init_step = ISTEP_OFF; nxt.phase = PH_IDLE; nxt.wait_count = 20'd0;
					end
				endcase
			end
		end else begin
			nxt.pin_e = 1'b0;
		end
	end

	always_comb begin
		result.lcd_e      = nxt.pin_e;
		result.lcd_rs     = nxt.pin_rs;
		result.lcd_rw     = nxt.pin_rw;
		result.lcd_nibble = nxt.pin_nib;
		result.bus_drive  = nxt.pin_drive;
		result.ready_res  = (nxt.phase == PH_IDLE);
		result.rejected   = rej;
	end

endmodule

[hdl/char_lcd_4bit_write_engine_unit.sv]
// Character-LCD 4-bit bus engine.
// req carries one clock tick of the display sequence per beat: op selects
// tick only, command byte, data byte or the power-up sequence; value is the
// byte; busy_line is the level of display D7 on that tick. res returns one
// beat per req beat: the pin levels after that tick, bus_drive, ready_res
// (engine idle) and rejected (request dropped because the engine was busy).
// A res beat comes out of a registered result queue; one beat is taken every
// cycle while the queue has room, since the whole tick update is a single pass
// of logic from the state registers back into them.
// A two-entry result queue sits on res: while res stalls, req still takes
// beats until both entries are full, then req.ready drops and stays low
// until res drains an entry.
// The config port writes unit_ticks (index 0) and long_ticks (index 1); write
// them only while the engine is idle.
// At reset the engine is idle, all pins are low with the bus released, the
// result queue is empty, and the wait registers hold 1200 and 24000 ticks.
module char_lcd_4bit_write_engine_unit import cle4w_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [19:0] cfg_data,
	cle4w_req_if.sink   req,
	cle4w_res_if.source res
);

	logic [15:0] unit_q;
	logic [19:0] long_q;
	state_t      st_q;
	state_t      st_next;
	res_t        res_next;
	res_t        slot_q [2];
	logic [1:0]  cnt_q;
	logic        accept;
	logic        pop;

	// Hold configuration; index codes cover both values of the index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= UNIT_RESET;
			long_q <= LONG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_UNIT: unit_q <= cfg_data[15:0];
				CFG_LONG: long_q <= cfg_data;
			endcase
		end
	end

	// Take a beat whenever the result queue has room
	assign req.ready = (cnt_q != 2'd2);
	assign accept    = req.valid && req.ready;
	assign pop       = res.valid && res.ready;

	cle4w_step u_step (
		.cur        (st_q),
		.op         (req.op),
		.value      (req.value),
		.busy_line  (req.busy_line),
		.unit_ticks (unit_q),
		.long_ticks (long_q),
		.nxt        (st_next),
		.result     (res_next)
	);

	// Advance the sequencer state once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (accept) begin
			st_q <= st_next;
		end
	end

	// Result queue: slot 0 is the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (!accept && pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pop) begin
			// Only possible with one entry held: replace the head
			slot_q[0] <= res_next;
		end else if (accept) begin
			slot_q[cnt_q[0]] <= res_next;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
		end
	end

	assign res.valid      = (cnt_q != 2'd0);
	assign res.lcd_e      = slot_q[0].lcd_e;
	assign res.lcd_rs     = slot_q[0].lcd_rs;
	assign res.lcd_rw     = slot_q[0].lcd_rw;
	assign res.lcd_nibble = slot_q[0].lcd_nibble;
	assign res.bus_drive  = slot_q[0].bus_drive;
	assign res.ready_res  = slot_q[0].ready_res;
	assign res.rejected   = slot_q[0].rejected;

	// A running segment always has ticks left to count
	a_wait_live: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase != PH_IDLE) |-> (st_q.wait_count != 20'd0))
		else $error("active phase with zero wait count");

	// E is never left high once the engine is idle
	a_idle_e_low: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_IDLE) |-> !st_q.pin_e)
		else $error("E high while idle");

	// A request taken while idle starts a sequence
	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.op != OP_TICK && st_q.phase == PH_IDLE) |=> (st_q.phase != PH_IDLE))
		else $error("accepted request did not start");

	// Queue never holds more than two results
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue overflow");

endmodule

[tb/sv/char_lcd_4bit_write_engine_unit_tb.sv]
`timescale 1ns / 100ps

module char_lcd_4bit_write_engine_unit_tb;
	import cle4w_pkg::*;

	// Cycle budget for the whole run: the slowest legal run, with the
	// receiver taking one beat in four throughout, stays under it, so
	// this only trips on a hang.
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef enum logic [1:0] {
		RUN_MIXED,     // requests whenever idle, stray requests while busy
		RUN_TICKS,     // plain ticks only
		RUN_POWER_UP   // open with the power-up sequence, then mixed
	} run_kind_t;

	typedef struct packed {
		logic [15:0] unit;
		logic [19:0] lng;
		logic [11:0] items;
		run_kind_t   kind;
	} wait_plan_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] value;
		logic       busy_line;
		logic       typed;
		res_t       want;
	} directed_row_t;

	// Register settings, one per stretch of random ticks. The first also
	// covers the directed rows. Short waits keep the sequences quick; the
	// widest unit only sees plain ticks, and the widest long wait closes the
	// run with a power-up that parks in its long wait.
	localparam int PLAN_LEN = 7;
	localparam wait_plan_t WAIT_PLAN [PLAN_LEN] = '{
		'{16'd1,    20'd2,       12'd450, RUN_MIXED},
		'{16'd0,    20'd0,       12'd250, RUN_MIXED},
		'{16'd2,    20'd1,       12'd300, RUN_MIXED},
		'{16'd4,    20'd3,       12'd250, RUN_MIXED},
		'{16'd1,    20'd7,       12'd250, RUN_MIXED},
		'{16'hFFFF, 20'hFFFFF,   12'd20,  RUN_TICKS},
		'{16'd1,    20'hFFFFF,   12'd200, RUN_POWER_UP}
	};

	// Pin levels read straight off the sequence: an idle tick right after
	// reset, and the first tick of a busy poll (E high, RW high, bus released,
	// nibble still at its reset level).
	localparam res_t PINS_IDLE = '{
		lcd_e: 1'b0, lcd_rs: 1'b0, lcd_rw: 1'b0, lcd_nibble: 4'h0,
		bus_drive: 1'b0, ready_res: 1'b1, rejected: 1'b0
	};
	localparam res_t PINS_POLL_START = '{
		lcd_e: 1'b1, lcd_rs: 1'b0, lcd_rw: 1'b1, lcd_nibble: 4'h0,
		bus_drive: 1'b0, ready_res: 1'b0, rejected: 1'b0
	};
	localparam res_t NO_PINS = '0;

	// Directed ticks, run with a one-tick unit and a two-tick long wait:
	// a command whose first poll sees the display busy, requests of every
	// kind turned away mid-byte, a data byte of all zeros, then the start
	// of the power-up sequence into its long wait.
	localparam int DIRECTED_LEN = 25;
	localparam directed_row_t DIRECTED [DIRECTED_LEN] = '{
		'{OP_TICK, 8'h00, 1'b0, 1'b1, PINS_IDLE},
		'{OP_CMD,  8'hFF, 1'b1, 1'b1, PINS_POLL_START},
		'{OP_DATA, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_INIT, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'hFF, 1'b1, 1'b0, NO_PINS},
		'{OP_CMD,  8'h5A, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b1, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b1, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_DATA, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'hFF, 1'b1, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_INIT, 8'hFF, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b1, 1'b0, NO_PINS},
		'{OP_TICK, 8'h00, 1'b0, 1'b0, NO_PINS}
	};

	localparam logic [7:0] POWER_CMDS [5] = '{8'h01, 8'h28, 8'h0F, 8'h06, 8'h01};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [19:0] cfg_data;

	cle4w_req_if req_ch ();
	cle4w_res_if res_ch ();

	char_lcd_4bit_write_engine_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	// ---------------------------------------------------------------
	// Engine predictor: its own copy of the wait registers and the
	// sequencer state, stepped once per accepted request beat.
	// ---------------------------------------------------------------
	logic [15:0] unit_q;
	logic [19:0] long_q;
	phase_t      ph;
	logic [19:0] wcount;
	logic [7:0]  bhold;
	logic        rs_hold;
	logic [3:0]  istep;
	logic        busy_hit;
	logic        pin_e, pin_rs, pin_rw, pin_drive;
	logic [3:0]  pin_nib;

	// Pin beats still owed by the block, oldest first
	res_t pin_queue [$];

	// A directed row with typed pins pushes those instead of the prediction
	logic typed_pending;
	res_t typed_pins;

	int unsigned cycle_count;
	int unsigned fails;
	int unsigned ticks_sent;
	int unsigned requests_sent;
	int unsigned requests_dropped;
	int unsigned power_ups;
	int unsigned beats_checked;

	// Sender bursts and receiver stall pattern
	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned stall_kind;
	int unsigned stall_left;
	int unsigned stall_phase;

	function automatic void reset_model();
		unit_q   = UNIT_RESET;
		long_q   = LONG_RESET;
		ph       = PH_IDLE;
		wcount   = '0;
		bhold    = '0;
		rs_hold  = 1'b0;
		istep    = ISTEP_OFF;
		busy_hit = 1'b0;
		pin_e    = 1'b0;
		pin_rs   = 1'b0;
		pin_rw   = 1'b0;
		pin_nib  = '0;
		pin_drive = 1'b0;
	endfunction

	// A zero unit register still waits one tick
	function automatic logic [19:0] unit_wait();
		return (unit_q == 16'd0) ? 20'd1 : {4'd0, unit_q};
	endfunction

	function automatic void enter_phase(phase_t p, logic [19:0] len);
		ph = p;
		wcount = (len == 20'd0) ? 20'd1 : len;
	endfunction

	function automatic void begin_byte(logic [7:0] b);
		bhold = b;
		busy_hit = 1'b0;
		enter_phase(PH_PE1, unit_wait());
	endfunction

	function automatic void begin_power_nibble(logic [7:0] b);
		bhold = b;
		enter_phase(PH_IN_HI, unit_wait());
	endfunction

	function automatic void go_idle();
		istep = ISTEP_OFF;
		ph = PH_IDLE;
		wcount = '0;
	endfunction

	// Move on once the current segment's wait has run out
	function automatic void next_phase();
		case (ph)
			PH_PE1: enter_phase(PH_PL1, unit_wait());
			PH_PL1: enter_phase(PH_PE2, unit_wait());
			PH_PE2: begin
				// poll again while D7 was high; commands settle two units
				if (busy_hit)
					enter_phase(PH_PE1, unit_wait());
				else
					enter_phase(PH_PRE, rs_hold ? unit_wait() : unit_wait() << 1);
			end
			PH_PRE:   enter_phase(PH_NH_HI, unit_wait());
			PH_NH_HI: enter_phase(PH_NH_LO, 20'd1);
			PH_NH_LO: enter_phase(PH_NL_HI, unit_wait());
			PH_NL_HI: enter_phase(PH_NL_LO, 20'd1);
			PH_NL_LO: begin
				// chain the next power-up command, if any
				if (istep >= ISTEP_CMD0 && istep < ISTEP_END) begin
					istep = istep + 4'd1;
					rs_hold = 1'b0;
					begin_byte(POWER_CMDS[istep - ISTEP_CMD0]);
				end else begin
					go_idle();
				end
			end
			PH_IN_HI: enter_phase(PH_IN_LO, 20'd1);
			PH_IN_LO: begin
				if (istep == ISTEP_N1) begin
					enter_phase(PH_IWAIT, long_q);
				end else if (istep == ISTEP_N2) begin
					enter_phase(PH_IWAIT, unit_wait());
				end else if (istep == ISTEP_N3) begin
					istep = ISTEP_N4;
					begin_power_nibble(NIB2_BYTE);
				end else if (istep == ISTEP_N4) begin
					istep = ISTEP_CMD0;
					rs_hold = 1'b0;
					begin_byte(POWER_CMDS[0]);
				end else begin
					go_idle();
				end
			end
			PH_IWAIT: begin
				istep = istep + 4'd1;
				begin_power_nibble(NIB3_BYTE);
			end
			default: go_idle();
		endcase
	endfunction

	function automatic void set_pins();
		case (ph)
			PH_PE1, PH_PE2: begin
				pin_e = 1'b1; pin_rs = 1'b0; pin_rw = 1'b1; pin_drive = 1'b0;
			end
			PH_PL1: begin
				pin_e = 1'b0; pin_rs = 1'b0; pin_rw = 1'b1; pin_drive = 1'b0;
			end
			PH_PRE: begin
				pin_e = 1'b0; pin_rs = 1'b0; pin_rw = 1'b1; pin_drive = 1'b1;
			end
			PH_NH_HI: begin
				pin_nib = bhold[7:4];
				pin_e = 1'b1; pin_rs = rs_hold; pin_rw = 1'b0; pin_drive = 1'b1;
			end
			PH_NL_HI: begin
				pin_nib = bhold[3:0];
				pin_e = 1'b1; pin_rs = rs_hold; pin_rw = 1'b0; pin_drive = 1'b1;
			end
			PH_NH_LO, PH_NL_LO: begin
				pin_e = 1'b0; pin_rs = rs_hold; pin_rw = 1'b0; pin_drive = 1'b1;
			end
			PH_IN_HI: begin
				pin_nib = bhold[7:4];
				pin_e = 1'b1; pin_rs = 1'b0; pin_rw = 1'b0; pin_drive = 1'b1;
			end
			PH_IN_LO, PH_IWAIT: begin
				pin_e = 1'b0; pin_rs = 1'b0; pin_rw = 1'b0; pin_drive = 1'b1;
			end
			default: pin_e = 1'b0;
		endcase
	endfunction

	// One display tick: take the request if idle, drive this segment's pins,
	// sample D7 on the last tick of the first E-high level, count the wait.
	function automatic res_t lcd_tick(logic [1:0] op, logic [7:0] value, logic busy);
		res_t r;
		r.rejected = 1'b0;
		if (op != OP_TICK) begin
			if (ph != PH_IDLE) begin
				r.rejected = 1'b1;
			end else if (op == OP_INIT) begin
				istep = ISTEP_N1;
				rs_hold = 1'b0;
				begin_power_nibble(NIB3_BYTE);
			end else begin
				istep = ISTEP_OFF;
				rs_hold = (op == OP_DATA);
				begin_byte(value);
			end
		end
		if (ph != PH_IDLE) begin
			set_pins();
			if (ph == PH_PE1 && wcount <= 20'd1)
				busy_hit = busy;
			if (wcount > 20'd0)
				wcount = wcount - 20'd1;
			if (wcount == 20'd0)
				next_phase();
		end else begin
			pin_e = 1'b0;
		end
		r.lcd_e      = pin_e;
		r.lcd_rs     = pin_rs;
		r.lcd_rw     = pin_rw;
		r.lcd_nibble = pin_nib;
		r.bus_drive  = pin_drive;
		r.ready_res  = (ph == PH_IDLE);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Handshake plumbing
	// ---------------------------------------------------------------

	// Receiver stall pattern: stretches of always-ready, coin-flip stalls,
	// and a mostly-stalled rhythm that lets the result queue fill up.
	function automatic logic sink_ready();
		if (stall_left == 0) begin
			stall_kind = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 80);
		end
		stall_left--;
		stall_phase++;
		case (stall_kind)
			0: return 1'b1;
			1: return logic'($urandom_range(0, 1));
			default: return (stall_phase % 4) == 0;
		endcase
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	// Advance one clock. Sample both handshakes on the pre-edge levels:
	// predict on every request beat taken, check every result beat taken,
	// then set the receiver's ready for the next edge.
	task automatic clock_beat(output bit req_taken);
		res_t fresh;
		res_t oldest;
		res_t got;
		@(posedge clk);
		req_taken = req_ch.valid && req_ch.ready;
		if (req_taken) begin
			fresh = lcd_tick(req_ch.op, req_ch.value, req_ch.busy_line);
			ticks_sent++;
			if (req_ch.op != OP_TICK)
				requests_sent++;
			if (fresh.rejected)
				requests_dropped++;
			else if (req_ch.op == OP_INIT)
				power_ups++;
			if (typed_pending) begin
				pin_queue.push_back(typed_pins);
				typed_pending = 1'b0;
			end else begin
				pin_queue.push_back(fresh);
			end
		end
		if (res_ch.valid && res_ch.ready) begin
			got = '{res_ch.lcd_e, res_ch.lcd_rs, res_ch.lcd_rw, res_ch.lcd_nibble,
				res_ch.bus_drive, res_ch.ready_res, res_ch.rejected};
			if (pin_queue.size() == 0) begin
				$error("result beat with no pending tick: got %h", got);
				fails++;
			end else begin
				oldest = pin_queue.pop_front();
				check_field("lcd_e", oldest.lcd_e, got.lcd_e);
				check_field("lcd_rs", oldest.lcd_rs, got.lcd_rs);
				check_field("lcd_rw", oldest.lcd_rw, got.lcd_rw);
				check_field("lcd_nibble", oldest.lcd_nibble, got.lcd_nibble);
				check_field("bus_drive", oldest.bus_drive, got.bus_drive);
				check_field("ready_res", oldest.ready_res, got.ready_res);
				check_field("rejected", oldest.rejected, got.rejected);
				beats_checked++;
			end
		end
		res_ch.ready <= sink_ready();
	endtask

	// Present one tick and hold it until taken. The sender runs in bursts;
	// at the end of each burst pick a gap, often none at all.
	task automatic send_tick(logic [1:0] op, logic [7:0] value, logic busy);
		bit taken;
		if (gap_left > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap_left) clock_beat(taken);
			gap_left = 0;
		end
		req_ch.valid     <= 1'b1;
		req_ch.op        <= op;
		req_ch.value     <= value;
		req_ch.busy_line <= busy;
		taken = 1'b0;
		while (!taken)
			clock_beat(taken);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
		end
	endtask

	task automatic drain_results();
		bit taken;
		req_ch.valid <= 1'b0;
		while (pin_queue.size() != 0)
			clock_beat(taken);
	endtask

	// Write both wait registers back to back; the engine must be idle
	task automatic write_waits(logic [15:0] unit, logic [19:0] lng);
		bit taken;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_UNIT;
		cfg_data  <= {4'd0, unit};
		clock_beat(taken);
		unit_q = unit;
		cfg_index <= CFG_LONG;
		cfg_data  <= lng;
		clock_beat(taken);
		long_q = lng;
		cfg_we <= 1'b0;
	endtask

	// Random ticks. When idle, mostly start a byte or the power-up so the
	// sequences get exercised end to end; while busy, mostly plain ticks
	// with the odd stray request that must be dropped. D7 reads high now
	// and then so polls repeat.
	task automatic run_random(run_kind_t kind, int unsigned count);
		logic [1:0]  op;
		logic [7:0]  value;
		logic        busy;
		int unsigned pick;
		for (int unsigned n = 0; n < count; n++) begin
			pick  = $urandom_range(0, 19);
			busy  = ($urandom_range(0, 9) < 3);
			value = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
				: 8'($urandom);
			if (kind == RUN_TICKS)
				op = OP_TICK;
			else if (kind == RUN_POWER_UP && n == 0)
				op = OP_INIT;
			else if (ph == PH_IDLE)
				op = (pick < 5) ? OP_TICK : (pick < 12) ? OP_CMD : (pick < 18) ? OP_DATA : OP_INIT;
			else
				op = (pick == 0) ? 2'($urandom_range(1, 3)) : OP_TICK;
			send_tick(op, value, busy);
		end
	endtask

	// ---------------------------------------------------------------
	// Clock, watchdog, main sequence
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: end the run if the main sequence hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("char_lcd_4bit_write_engine_unit_tb: errors");
		$finish;
	end

	initial begin
		bit taken;

		// Drive every input to a known level and hold reset
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_UNIT;
		cfg_data         <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.op        <= OP_TICK;
		req_ch.value     <= '0;
		req_ch.busy_line <= 1'b0;
		res_ch.ready     <= 1'b0;

		reset_model();
		typed_pending    = 1'b0;
		typed_pins       = '0;
		fails            = 0;
		ticks_sent       = 0;
		requests_sent    = 0;
		requests_dropped = 0;
		power_ups        = 0;
		beats_checked    = 0;
		burst_left       = $urandom_range(1, 40);
		gap_left         = 0;
		stall_kind       = 0;
		stall_left       = 0;
		stall_phase      = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Shrink the waits before anything moves, then walk the directed rows
		write_waits(WAIT_PLAN[0].unit, WAIT_PLAN[0].lng);
		foreach (DIRECTED[i]) begin
			typed_pending = DIRECTED[i].typed;
			typed_pins    = DIRECTED[i].want;
			send_tick(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].busy_line);
		end

		// Random stretches. Between settings, tick the engine back to idle,
		// drain every owed result, and only then rewrite the registers.
		for (int p = 0; p < PLAN_LEN; p++) begin
			if (p != 0) begin
				while (ph != PH_IDLE)
					send_tick(OP_TICK, 8'($urandom), 1'b0);
				drain_results();
				write_waits(WAIT_PLAN[p].unit, WAIT_PLAN[p].lng);
			end
			run_random(WAIT_PLAN[p].kind, WAIT_PLAN[p].items);
		end

		// Collect the tail, then keep clocking to watch for stray beats
		drain_results();
		repeat (8) clock_beat(taken);

		$display("summary: %0d ticks, %0d requests (%0d dropped while busy), %0d power-ups",
			ticks_sent, requests_sent, requests_dropped, power_ups);
		$display("summary: %0d pin beats checked over %0d wait settings, %0d mismatches",
			beats_checked, PLAN_LEN, fails);
		if (fails == 0 && pin_queue.size() == 0)
			$display("char_lcd_4bit_write_engine_unit_tb: clean");
		else
			$display("char_lcd_4bit_write_engine_unit_tb: errors");
		$finish;
	end

endmodule

[sim.f]
hdl/cle4w_pkg.sv
hdl/cle4w_req_if.sv
hdl/cle4w_res_if.sv
hdl/cle4w_step.sv
hdl/char_lcd_4bit_write_engine_unit.sv
tb/sv/char_lcd_4bit_write_engine_unit_tb.sv
